// File: design/tsw_pkg.sv
// tsw_pkg: shared widths, register indexes and the tanh table builder for the
// tape saturation waveshaper. The table builder runs at elaboration only.
// No dependencies.
package tsw_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN  = 2'd2;

   localparam logic [CFG_W-1:0]        DRIVE_RESET = 16'd4096;
   localparam logic signed [CFG_W-1:0] BIAS_RESET  = 16'sd0;
   localparam logic [CFG_W-1:0]        GAIN_RESET  = 16'd2731;

   // smoother weights 0.05 and 0.95 in Q0.16
   localparam logic [CFG_W-1:0] SMOOTH_OLD_WEIGHT = 16'd3277;
   localparam logic [CFG_W-1:0] SMOOTH_NEW_WEIGHT = 16'd62259;

   // serial multiplier: signed A times unsigned B, one B digit per cycle
   localparam int MUL_A_W     = 29;
   localparam int MUL_B_W     = 24;
   localparam int MUL_DIGIT_W = 8;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int SUM_W  = 42;
   localparam int MAG_W  = 25;
   localparam int ARG_W  = 28;
   localparam int FRAC_W = 26;
   localparam int M_W    = 28;

   localparam logic [SAMPLE_W-1:0]        FULL_SCALE = 24'h7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

   localparam int TANH_MAX_ENTRIES = 4096;
   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

   typedef logic [SAMPLE_W-1:0] tanh_rom_type [TANH_MAX_ENTRIES];

   // long division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'b0, a} * {64'b0, b};
      return wide[125:62];
   endfunction

   // entry i = tanh(8*i/n) in unsigned Q1.23, rounded
   function automatic tanh_rom_type build_tanh_rom(input int n);
      tanh_rom_type rom;
      logic [63:0]  r;
      logic [63:0]  term;
      logic [63:0]  e;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  t;
      rom  = '{default: '0};
      r    = Q62_ONE;
      term = Q62_ONE;
      e    = Q62_ONE;
      for (int k = 1; k < 40; k++) begin
         term = udiv64(udiv64(term, 64'(n)) * 64'd16, 64'(k));
         if ((k % 2) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (int i = 0; i < n; i++) begin
         num = (Q62_ONE - e) >> 30;
         den = (Q62_ONE + e) >> 30;
         t   = udiv64((num << 23) + (den >> 1), den);
         rom[i] = (t > 64'(FULL_SCALE)) ? FULL_SCALE : t[SAMPLE_W-1:0];
         e = mul_q62(e, r);
      end
      return rom;
   endfunction

endpackage

// File: design/tsw_serial_mul.sv
// tsw_serial_mul: digit-serial multiplier, signed A by unsigned B, one B digit
// per cycle through a shift-right accumulator.
// Depends on tsw_pkg.
module tsw_serial_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tsw_pkg::MUL_A_W-1:0]   mul_a,
   input  logic [tsw_pkg::MUL_B_W-1:0]          mul_b,
   output logic                                 done,
   output logic signed [tsw_pkg::PROD_W-1:0]    product
);

   localparam int A_W   = tsw_pkg::MUL_A_W;
   localparam int B_W   = tsw_pkg::MUL_B_W;
   localparam int DW    = tsw_pkg::MUL_DIGIT_W;
   localparam int NDIG  = tsw_pkg::MUL_B_W / tsw_pkg::MUL_DIGIT_W;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam int ACC_W = A_W + DW + 1;
   localparam int CAT_W = ACC_W + B_W;

   logic signed [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]          b_ff, b_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [B_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic signed [ACC_W-1:0] pp;
   logic signed [ACC_W-1:0] sum;
   logic [CAT_W-1:0]        cat;

   always_comb begin
      pp      = ACC_W'(a_ff) * ACC_W'($signed({1'b0, b_ff[DW-1:0]}));
      sum     = acc_ff + pp;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = mul_a;
         b_in   = mul_b;
         acc_in = '0;
         cnt_in = CNT_W'(NDIG);
      end else if (cnt_ff != '0) begin
         acc_in  = sum >>> DW;
         lo_in   = {sum[DW-1:0], lo_ff[B_W-1:DW]};
         b_in    = b_ff >> DW;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign cat     = {acc_ff, lo_ff};
   assign product = $signed(cat[tsw_pkg::PROD_W-1:0]);
   assign done    = done_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> cnt_ff == '0)
      else $error("multiplier started while busy");

   a_done_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(NDIG + 1) done_ff)
      else $error("multiplier result late");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held");

endmodule

// File: design/tape_saturation_waveshaper.sv
// tape_saturation_waveshaper: one-pole smoother, bias, tanh table with
// interpolation, output gain and saturation. Depends on tsw_pkg, tsw_serial_mul.
//
// Usage:
//   req_* carries one signed Q1.23 sample a beat; req_stall is high while a
//   sample is being worked on. rsp_* gives one saturated sample a beat from an
//   output register; a finished sample waits there while rsp_stall is high and
//   the next request beat is taken meanwhile. The block stops before loading
//   a further result until the waiting one has gone.
//   csr_* writes drive, bias_level and output_gain (index 0, 1, 2); csr_ready
//   is always high. Write only when no sample is in flight.
// Sequencing:
//   A new request is taken only once the previous sample's result has been
//   loaded into the output register. All products go through one 8-bit
//   digit-serial multiplier, six products per sample (five when the argument
//   is past the table).
// Reset: synchronous; clears the smoother to zero and loads the register
//   defaults (drive 1.0, bias 0, gain 2731). No clearing pass.
module tape_saturation_waveshaper #(
   parameter int TANH_TABLE_ENTRIES = 256
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [tsw_pkg::SAMPLE_W-1:0]      req_sample_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [tsw_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tsw_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [tsw_pkg::CFG_W-1:0]                csr_wdata
);

   localparam int SW     = tsw_pkg::SAMPLE_W;
   localparam int N_W    = $clog2(TANH_TABLE_ENTRIES + 1);
   localparam int ADDR_W = $clog2(TANH_TABLE_ENTRIES);
   localparam int P_W    = tsw_pkg::ARG_W + N_W;
   localparam int IDX_W  = P_W - tsw_pkg::FRAC_W;

   localparam logic [IDX_W-1:0] N_IDX  = IDX_W'(TANH_TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] N_LAST = IDX_W'(TANH_TABLE_ENTRIES - 1);

   localparam tsw_pkg::tanh_rom_type TANH_ROM = tsw_pkg::build_tanh_rom(TANH_TABLE_ENTRIES);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_MUL_Y   = 12'b0000_0000_0010,
      ST_MUL_X   = 12'b0000_0000_0100,
      ST_BIAS    = 12'b0000_0000_1000,
      ST_MUL_D   = 12'b0000_0001_0000,
      ST_MUL_N   = 12'b0000_0010_0000,
      ST_ROM_LO  = 12'b0000_0100_0000,
      ST_ROM_HI  = 12'b0000_1000_0000,
      ST_ROM_DIF = 12'b0001_0000_0000,
      ST_MUL_F   = 12'b0010_0000_0000,
      ST_MUL_G   = 12'b0100_0000_0000,
      ST_OUT     = 12'b1000_0000_0000
   } state_type;

   state_type                          state_ff, state_in;
   logic                               go_ff, go_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]               rsp_data_ff, rsp_data_in;
   logic [tsw_pkg::CFG_W-1:0]          drive_ff, drive_in;
   logic signed [tsw_pkg::CFG_W-1:0]   bias_ff, bias_in;
   logic [tsw_pkg::CFG_W-1:0]          gain_ff, gain_in;
   logic signed [SW-1:0]               y_ff, y_in;
   logic signed [SW-1:0]               x_ff, x_in;
   logic signed [tsw_pkg::SUM_W-1:0]   s_ff, s_in;
   logic                               neg_ff, neg_in;
   logic [tsw_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic [tsw_pkg::ARG_W-1:0]          arg_ff, arg_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [tsw_pkg::FRAC_W-1:0]         frac_ff, frac_in;
   logic                               over_ff, over_in;
   logic                               last_ff, last_in;
   logic [SW-1:0]                      rom_ff;
   logic [SW-1:0]                      lo_ff, lo_in;
   logic [SW-1:0]                      diff_ff, diff_in;
   logic [SW-1:0]                      t_ff, t_in;
   logic [tsw_pkg::M_W-1:0]            m_ff, m_in;

   logic [ADDR_W-1:0]                  rom_addr;
   logic signed [tsw_pkg::MUL_A_W-1:0] mul_a;
   logic [tsw_pkg::MUL_B_W-1:0]        mul_b;
   logic                               mul_done;
   logic signed [tsw_pkg::PROD_W-1:0]  product;

   logic signed [tsw_pkg::SUM_W-1:0]   sum_x;
   logic signed [tsw_pkg::MAG_W-1:0]   v;
   logic [40:0]                        rnd_d;
   logic [P_W-1:0]                     p;
   logic [SW-1:0]                      hi_v;
   logic [50:0]                        rnd_f;
   logic [24:0]                        inc_f;
   logic [39:0]                        rnd_g;
   logic signed [tsw_pkg::M_W:0]       sm;
   logic signed [29:0]                 res;

   tsw_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_Y: begin
            mul_a = tsw_pkg::MUL_A_W'(y_ff);
            mul_b = tsw_pkg::MUL_B_W'(tsw_pkg::SMOOTH_OLD_WEIGHT);
         end
         ST_MUL_X: begin
            mul_a = tsw_pkg::MUL_A_W'(x_ff);
            mul_b = tsw_pkg::MUL_B_W'(tsw_pkg::SMOOTH_NEW_WEIGHT);
         end
         ST_MUL_D: begin
            mul_a = $signed(tsw_pkg::MUL_A_W'(mag_ff));
            mul_b = tsw_pkg::MUL_B_W'(drive_ff);
         end
         ST_MUL_N: begin
            mul_a = $signed(tsw_pkg::MUL_A_W'(arg_ff));
            mul_b = tsw_pkg::MUL_B_W'(TANH_TABLE_ENTRIES);
         end
         ST_MUL_F: begin
            mul_a = $signed(tsw_pkg::MUL_A_W'(frac_ff));
            mul_b = diff_ff;
         end
         ST_MUL_G: begin
            mul_a = $signed(tsw_pkg::MUL_A_W'(t_ff));
            mul_b = tsw_pkg::MUL_B_W'(gain_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath pieces
   always_comb begin
      sum_x = s_ff + $signed(product[tsw_pkg::SUM_W-1:0])
              + $signed(tsw_pkg::SUM_W'(32768));
      v     = tsw_pkg::MAG_W'(y_ff) + $signed({bias_ff[tsw_pkg::CFG_W-1], bias_ff, 8'b0});
      rnd_d = product[40:0] + 41'd2048;
      p     = product[P_W-1:0];
      hi_v  = last_ff ? tsw_pkg::FULL_SCALE : rom_ff;
      if (hi_v < lo_ff) begin
         hi_v = lo_ff;
      end
      rnd_f = {1'b0, product[49:0]} + (51'd1 << 25);
      inc_f = rnd_f[50:26];
      rnd_g = {1'b0, product[38:0]} + 40'd2048;
      sm    = neg_ff ? -$signed({1'b0, m_ff}) : $signed({1'b0, m_ff});
      res   = 30'(sm) - 30'($signed({bias_ff, 7'b0}));
   end

   assign rom_addr = (state_ff == ST_ROM_LO) ? idx_ff[ADDR_W-1:0]
                                              : idx_ff[ADDR_W-1:0] + ADDR_W'(1);

   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      drive_in     = drive_ff;
      bias_in      = bias_ff;
      gain_in      = gain_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      arg_in       = arg_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      over_in      = over_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      diff_in      = diff_ff;
      t_in         = t_ff;
      m_in         = m_ff;

      if (csr_valid) begin
         case (csr_index)
            tsw_pkg::CSR_DRIVE: drive_in = csr_wdata;
            tsw_pkg::CSR_BIAS:  bias_in  = $signed(csr_wdata);
            tsw_pkg::CSR_GAIN:  gain_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               go_in    = 1'b1;
               state_in = ST_MUL_Y;
            end
         end
         ST_MUL_Y: begin
            if (mul_done) begin
               s_in     = product[tsw_pkg::SUM_W-1:0];
               go_in    = 1'b1;
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            if (mul_done) begin
               y_in     = sum_x[SW+15:16];
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            neg_in   = v[tsw_pkg::MAG_W-1];
            mag_in   = v[tsw_pkg::MAG_W-1] ? tsw_pkg::MAG_W'(-v) : tsw_pkg::MAG_W'(v);
            go_in    = 1'b1;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            if (mul_done) begin
               arg_in   = rnd_d[39:12];
               go_in    = 1'b1;
               state_in = ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            if (mul_done) begin
               idx_in   = p[P_W-1:tsw_pkg::FRAC_W];
               frac_in  = p[tsw_pkg::FRAC_W-1:0];
               state_in = ST_ROM_LO;
            end
         end
         ST_ROM_LO: begin
            over_in  = (idx_ff >= N_IDX);
            last_in  = (idx_ff >= N_LAST);
            state_in = ST_ROM_HI;
         end
         ST_ROM_HI: begin
            lo_in    = rom_ff;
            state_in = ST_ROM_DIF;
         end
         ST_ROM_DIF: begin
            diff_in = hi_v - lo_ff;
            go_in   = 1'b1;
            if (over_ff) begin
               t_in     = tsw_pkg::FULL_SCALE;
               state_in = ST_MUL_G;
            end else begin
               state_in = ST_MUL_F;
            end
         end
         ST_MUL_F: begin
            if (mul_done) begin
               t_in     = lo_ff + inc_f[SW-1:0];
               go_in    = 1'b1;
               state_in = ST_MUL_G;
            end
         end
         ST_MUL_G: begin
            if (mul_done) begin
               m_in     = rnd_g[39:12];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (res > 30'(tsw_pkg::SAMPLE_MAX)) begin
                  rsp_data_in = tsw_pkg::SAMPLE_MAX;
               end else if (res < 30'(tsw_pkg::SAMPLE_MIN)) begin
                  rsp_data_in = tsw_pkg::SAMPLE_MIN;
               end else begin
                  rsp_data_in = res[SW-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= tsw_pkg::DRIVE_RESET;
         bias_ff      <= tsw_pkg::BIAS_RESET;
         gain_ff      <= tsw_pkg::GAIN_RESET;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         drive_ff     <= drive_in;
         bias_ff      <= bias_in;
         gain_ff      <= gain_in;
         y_ff         <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      s_ff        <= s_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      arg_ff      <= arg_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      over_ff     <= over_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      diff_ff     <= diff_in;
      t_ff        <= t_in;
      m_ff        <= m_in;
      rom_ff      <= TANH_ROM[rom_addr];
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign csr_ready      = 1'b1;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside output state");

   a_over_full_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_G && over_ff) |-> t_ff == tsw_pkg::FULL_SCALE)
      else $error("tanh past table not full scale");

   a_interp_above_lo: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_G && !over_ff) |-> t_ff >= lo_ff)
      else $error("interpolated tanh below lower entry");

   a_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_Y || state_ff == ST_MUL_X ||
                    state_ff == ST_MUL_D || state_ff == ST_MUL_N ||
                    state_ff == ST_MUL_F || state_ff == ST_MUL_G))
      else $error("product returned outside a multiply state");

endmodule

// File: sim/tb_tape_saturation_waveshaper.sv
// tb_tape_saturation_waveshaper: self-checking bench for the tape saturation
// waveshaper. Predicts each output sample in a small scoreboard class and
// drives random gaps and stalls. Depends on tsw_pkg and the block's RTL.
module tb_tape_saturation_waveshaper;

   localparam int TABLE_N    = 256;
   localparam int IDLE_LIMIT = 3000;
   localparam int TAIL       = 60;

   typedef logic signed [tsw_pkg::SAMPLE_W-1:0] sample_type;

   class shaped_sample_board_type;
      bit [tsw_pkg::SAMPLE_W-1:0]        tanh_rom [TABLE_N];
      longint                            smoothed;
      bit [tsw_pkg::CFG_W-1:0]           drive_q;
      bit signed [tsw_pkg::CFG_W-1:0]    bias_q;
      bit [tsw_pkg::CFG_W-1:0]           gain_q;
      sample_type                        pending_out [$];
      int                                mismatches;
      int                                checked;

      function new();
         bit [63:0]  r;
         bit [63:0]  term;
         bit [63:0]  e;
         bit [63:0]  num;
         bit [63:0]  den;
         bit [63:0]  t;
         bit [127:0] wide;
         r    = 64'h4000_0000_0000_0000;
         term = r;
         e    = r;
         // exp(-16/N) by series, Q62
         for (int k = 1; k < 40; k++) begin
            term = term / 64'(TABLE_N) * 64'd16 / 64'(k);
            if (k % 2 == 1) begin
               r = r - term;
            end else begin
               r = r + term;
            end
         end
         for (int i = 0; i < TABLE_N; i++) begin
            num = (64'h4000_0000_0000_0000 - e) >> 30;
            den = (64'h4000_0000_0000_0000 + e) >> 30;
            t   = ((num << 23) + den / 2) / den;
            tanh_rom[i] = (t > 64'(tsw_pkg::FULL_SCALE)) ? tsw_pkg::FULL_SCALE : t[23:0];
            wide = {64'b0, e} * {64'b0, r};
            e    = wide[125:62];
         end
         smoothed   = 0;
         drive_q    = tsw_pkg::DRIVE_RESET;
         bias_q     = tsw_pkg::BIAS_RESET;
         gain_q     = tsw_pkg::GAIN_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [tsw_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [tsw_pkg::CFG_W-1:0] data);
         case (idx)
            tsw_pkg::CSR_DRIVE: drive_q = data;
            tsw_pkg::CSR_BIAS:  bias_q  = data;
            tsw_pkg::CSR_GAIN:  gain_q  = data;
            default: ;
         endcase
      endfunction

      function void take_sample(sample_type x);
         longint    s;
         longint    v;
         longint    res;
         bit [63:0] mag;
         bit [63:0] a;
         bit [63:0] p;
         bit [63:0] idx;
         bit [63:0] f;
         bit [63:0] lo;
         bit [63:0] hi;
         bit [63:0] t;
         bit [63:0] m;
         bit        neg;
         s        = 64'sd3277 * smoothed + 64'sd62259 * longint'(x);
         smoothed = (s + 64'sd32768) >>> 16;
         v   = smoothed + longint'(bias_q) * 256;
         neg = v < 0;
         mag = neg ? -v : v;
         a   = (mag * drive_q + 64'd2048) >> 12;
         p   = a * 64'(TABLE_N);
         idx = p >> 26;
         f   = p & ((64'd1 << 26) - 64'd1);
         if (idx >= 64'(TABLE_N)) begin
            t = 64'(tsw_pkg::FULL_SCALE);
         end else begin
            lo = tanh_rom[idx];
            hi = (idx + 1 < 64'(TABLE_N)) ? 64'(tanh_rom[idx + 1])
                                          : 64'(tsw_pkg::FULL_SCALE);
            if (hi < lo) begin
               hi = lo;
            end
            t = lo + (((hi - lo) * f + (64'd1 << 25)) >> 26);
         end
         m   = (t * gain_q + 64'd2048) >> 12;
         res = neg ? -longint'(m) : longint'(m);
         res = res - longint'(bias_q) * 128;
         if (res > longint'(tsw_pkg::SAMPLE_MAX)) begin
            res = tsw_pkg::SAMPLE_MAX;
         end
         if (res < longint'(tsw_pkg::SAMPLE_MIN)) begin
            res = tsw_pkg::SAMPLE_MIN;
         end
         pending_out.push_back(res[23:0]);
      endfunction

      function void check_sample(sample_type got);
         sample_type want;
         checked++;
         if (pending_out.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected output sample, expected none, got %0d", $time, got);
         end else begin
            want = pending_out.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
            end
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   sample_type                          req_sample_in  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   sample_type                          rsp_sample_out;
   logic                                csr_valid      = 1'b0;
   logic                                csr_ready;
   logic [tsw_pkg::CSR_INDEX_W-1:0]     csr_index      = tsw_pkg::CSR_DRIVE;
   logic [tsw_pkg::CFG_W-1:0]           csr_wdata      = '0;

   shaped_sample_board_type board;
   bit         steady        = 1'b0;
   int         stall_left    = 0;
   int         idle_cycles   = 0;
   int         samples_sent  = 0;
   int         settings_used = 0;
   sample_type last_sample   = '0;

   tape_saturation_waveshaper #(.TANH_TABLE_ENTRIES(TABLE_N)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] matched_gain(logic [15:0] d);
      real g;
      g = 262144.0 / (1.5 * $sqrt(real'(d)));
      if (g > 65535.0) begin
         return 16'hFFFF;
      end
      return 16'($rtoi(g));
   endfunction

   function automatic sample_type next_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'($urandom);
         4, 5:       return sample_type'(int'($urandom_range(0, 8191)) - 4096);
         6:          return $urandom_range(0, 1) ? tsw_pkg::SAMPLE_MAX : tsw_pkg::SAMPLE_MIN;
         7, 8:       return last_sample;
         default:    return sample_type'(int'($urandom_range(0, 4194303)) - 2097152);
      endcase
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_sample(rsp_sample_out);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_sample(sample_type x);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.take_sample(x);
      last_sample = x;
      samples_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_out.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [tsw_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      board.set_register(idx, data);
   endtask

   task automatic write_settings(logic [15:0] d, logic [15:0] b, logic [15:0] g);
      drain();
      put_reg(tsw_pkg::CSR_DRIVE, d);
      put_reg(tsw_pkg::CSR_BIAS, b);
      put_reg(tsw_pkg::CSR_GAIN, g);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [15:0] d;
      logic [15:0] b;
      logic [15:0] g;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: extremes and a settled full-scale input
      send_sample('0);
      repeat (3) send_sample(tsw_pkg::SAMPLE_MAX);
      send_sample(tsw_pkg::SAMPLE_MIN);
      send_sample(tsw_pkg::SAMPLE_MIN);
      send_sample(-24'sd1);
      send_sample(24'sd1);
      send_sample(24'sh15_5555);
      send_sample(-24'sh2A_AAAA);

      // argument past the table, output overflow
      write_settings(16'hFFFF, 16'h7FFF, 16'hFFFF);
      send_sample(tsw_pkg::SAMPLE_MAX);
      send_sample(tsw_pkg::SAMPLE_MIN);
      send_sample('0);
      write_settings(16'hFFFF, 16'h8000, 16'hFFFF);
      send_sample(tsw_pkg::SAMPLE_MIN);

      // zero drive, zero gain
      write_settings(16'h0000, 16'h8000, 16'h0000);
      send_sample(tsw_pkg::SAMPLE_MAX);
      send_sample(tsw_pkg::SAMPLE_MIN);

      write_settings(16'h0001, 16'h0000, 16'hFFFF);
      send_sample(24'sd12345);
      send_sample(-24'sd12345);
      send_sample(tsw_pkg::SAMPLE_MAX);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 5)
            0: begin
               d = 16'($urandom_range(1024, 32768));
               b = 16'($signed($urandom_range(0, 4095)) - 2048);
               g = matched_gain(d);
            end
            1: begin
               d = 16'hFFFF;
               b = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               g = matched_gain(d);
            end
            2: begin
               d = 16'($urandom_range(1, 512));
               b = 16'($signed($urandom_range(0, 1023)) - 512);
               g = matched_gain(d);
            end
            3: begin
               d = 16'($urandom);
               b = 16'($urandom);
               g = 16'($urandom);
            end
            default: begin
               d = 16'd4096;
               b = 16'($urandom);
               g = 16'hFFFF;
            end
         endcase
         write_settings(d, b, g);
         steady = (ph % 4 == 3);
         repeat (63) send_sample(next_sample());
         steady = 1'b0;
      end

      drain();
      repeat (TAIL) @(posedge clock);
      $display("covered %0d samples across %0d register settings, %0d outputs checked",
               samples_sent, settings_used + 1, board.checked);
      $display("%0d mismatching outputs, %0d still outstanding",
               board.mismatches, board.pending_out.size());
      if (board.mismatches == 0 && board.pending_out.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
